// ----- hdl/polynomial_bisection_root_finder_macros.svh -----
// ----------------------------------------------------------------------------
// polynomial_bisection_root_finder_macros.svh
// Assertion macros used by the checker file of the root finder.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_BISECTION_ROOT_FINDER_MACROS_SVH
`define POLYNOMIAL_BISECTION_ROOT_FINDER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PBRF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PBRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pbrf_pkg.sv -----
// ----------------------------------------------------------------------------
// pbrf_pkg
// Shared constants, codes and controller/datapath interface types of the
// polynomial bisection root finder.
// ----------------------------------------------------------------------------
`default_nettype none

package pbrf_pkg;

    localparam int MAX_COEFFS  = 64;
    localparam int COEF_AW     = $clog2(MAX_COEFFS);
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 6;
    localparam int DEG_W       = 6;
    localparam int TOL_W       = 31;
    localparam int CFG_W       = 31;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 32;
    localparam int STATUS_W    = 2;

    localparam logic [TOL_W-1:0]     TOL_RESET       = 31'd7;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 1'd1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_SOLVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND   = 2'd0,
        ST_INVALID = 2'd1,
        ST_WRITTEN = 2'd2
    } res_status_t;

    typedef struct packed {
        logic        take_in;
        logic        coef_wr;
        logic        rd_first;
        logic        ld_first;
        logic        mul;
        logic        acc;
        logic        save_fa;
        logic        set_mid;
        logic        side;
        logic        out_load;
        res_status_t out_status;
    } pbrf_cmd_t;

    typedef struct packed {
        logic last;
        logic deg_zero;
        logic p_zero;
        logic invalid;
        logic stop;
    } pbrf_stat_t;

endpackage

`default_nettype wire

// ----- hdl/polynomial_bisection_root_finder.sv -----
// Sequence: a write result is loaded in the result state entered when its request is accepted;
// a solve request evaluates the polynomial at both ends, then at one midpoint per halving,
// and stops early on an exact zero at a midpoint or on an invalid interval.
// Throughput: one request in work at a time; the next is taken from the cycle after its
// result is loaded; a stalled result holds the controller.
// Reset (rst_n, asynchronous, active low) clears control, configuration and coefficients.
// ----------------------------------------------------------------------------
// polynomial_bisection_root_finder
// Top level: stream ports, controller and datapath of the bisection root
// finder over a Horner-evaluated Q16.16 polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_bisection_root_finder (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [pbrf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pbrf_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // coef_index[5:0], coef_value[37:6], left_end[69:38], right_end[101:70]
    input  wire logic [pbrf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // action[0]
    input  wire logic [0:0]                         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // root_value[31:0]
    output logic [pbrf_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // status[1:0]
    output logic [pbrf_pkg::STATUS_W-1:0]           m_axis_tuser
);

    import pbrf_pkg::*;

    pbrf_cmd_t                cmd;
    pbrf_stat_t               st;
    logic signed [DATA_W-1:0] root_value;

    pbrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser[0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    pbrf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .coef_index (s_axis_tdata[5:0]),
        .coef_value (s_axis_tdata[37:6]),
        .left_end   (s_axis_tdata[69:38]),
        .right_end  (s_axis_tdata[101:70]),
        .cmd        (cmd),
        .st         (st),
        .root_value (root_value),
        .status     (m_axis_tuser)
    );

    assign m_axis_tdata = root_value;

endmodule

`default_nettype wire

// ----- hdl/pbrf_ram.sv -----
// ----------------------------------------------------------------------------
// pbrf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         q
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pbrf_dp.sv -----
// ----------------------------------------------------------------------------
// pbrf_dp
// Datapath: configuration registers, coefficient store, Horner multiply-add,
// interval registers, midpoint and width logic, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrf_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [pbrf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pbrf_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic [pbrf_pkg::IDX_W-1:0]           coef_index,
    input  wire logic signed [pbrf_pkg::DATA_W-1:0]   coef_value,
    input  wire logic signed [pbrf_pkg::DATA_W-1:0]   left_end,
    input  wire logic signed [pbrf_pkg::DATA_W-1:0]   right_end,
    input  wire pbrf_pkg::pbrf_cmd_t                  cmd,
    output pbrf_pkg::pbrf_stat_t                      st,
    output logic signed [pbrf_pkg::DATA_W-1:0]        root_value,
    output logic [pbrf_pkg::STATUS_W-1:0]             status
);

    import pbrf_pkg::*;

    logic [DEG_W-1:0]          poly_degree_reg;
    logic [TOL_W-1:0]          tolerance_reg;
    logic [MAX_COEFFS-1:0]     vld_reg;
    logic                      vld_q_reg;
    logic [COEF_AW-1:0]        i_reg;
    logic signed [DATA_W-1:0]  a_reg;
    logic signed [DATA_W-1:0]  b_reg;
    logic signed [DATA_W-1:0]  x_reg;
    logic signed [DATA_W-1:0]  p_reg;
    logic signed [DATA_W-1:0]  p_next;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic                      fa_neg_reg;
    logic                      fa_zero_reg;
    logic signed [DATA_W-1:0]  root_reg;
    logic [STATUS_W-1:0]       status_reg;

    logic [COEF_AW-1:0]        wr_addr;
    logic                      wr_in_range;
    logic                      ram_we;
    logic                      ram_re;
    logic [COEF_AW-1:0]        rd_addr;
    logic [DATA_W-1:0]         ram_q;
    logic signed [DATA_W-1:0]  coef;
    logic [COEF_AW-1:0]        deg_eff;
    logic signed [2*DATA_W-1:0] shifted;
    logic signed [DATA_W-1:0]  ps;
    logic signed [DATA_W:0]    sum;
    logic signed [DATA_W:0]    mid_sum;
    logic signed [DATA_W-1:0]  mid;
    logic signed [DATA_W:0]    diff;
    logic [DATA_W:0]           wid;

    assign wr_addr     = COEF_AW'(coef_index);
    assign wr_in_range = (32'(coef_index) < MAX_COEFFS);
    assign ram_we      = cmd.coef_wr && wr_in_range;
    assign ram_re      = cmd.rd_first || cmd.mul;
    assign rd_addr     = cmd.rd_first ? '0 : i_reg;
    assign deg_eff     = (32'(poly_degree_reg) >= MAX_COEFFS) ?
                         COEF_AW'(MAX_COEFFS - 1) : COEF_AW'(poly_degree_reg);

    pbrf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_COEFFS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (coef_value),
        .re    (ram_re),
        .raddr (rd_addr),
        .q     (ram_q)
    );

    assign coef = vld_q_reg ? $signed(ram_q) : '0;

    // floor shift of the product, then saturate, add and saturate again
    always_comb
    begin
        shifted = prod_reg >>> 16;
        if (shifted > 64'sd2147483647)
        begin
            ps = 32'sh7fffffff;
        end
        else if (shifted < -64'sd2147483648)
        begin
            ps = 32'sh80000000;
        end
        else
        begin
            ps = shifted[DATA_W-1:0];
        end
        sum = {ps[DATA_W-1], ps} + {coef[DATA_W-1], coef};
        if (sum[DATA_W] != sum[DATA_W-1])
        begin
            p_next = sum[DATA_W] ? 32'sh80000000 : 32'sh7fffffff;
        end
        else
        begin
            p_next = sum[DATA_W-1:0];
        end
    end

    assign mid_sum = {a_reg[DATA_W-1], a_reg} + {b_reg[DATA_W-1], b_reg};
    assign mid     = mid_sum[DATA_W:1];
    assign diff    = {a_reg[DATA_W-1], a_reg} - {b_reg[DATA_W-1], b_reg};
    assign wid     = diff[DATA_W] ? $unsigned(-diff) : $unsigned(diff);

    assign st.last     = (i_reg == deg_eff);
    assign st.deg_zero = (deg_eff == '0);
    assign st.p_zero   = (p_reg == '0);
    assign st.invalid  = fa_zero_reg || (p_reg == '0) || (p_reg[DATA_W-1] == fa_neg_reg);
    assign st.stop     = (wid <= {2'b00, tolerance_reg}) || (wid <= 33'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_degree_reg <= '0;
            tolerance_reg   <= TOL_RESET;
            vld_reg         <= '0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_index == REG_POLY_DEGREE))
            begin
                poly_degree_reg <= cfg_data[DEG_W-1:0];
            end
            if (cfg_wr_en && (cfg_index == REG_TOLERANCE))
            begin
                tolerance_reg <= cfg_data[TOL_W-1:0];
            end
            if (ram_we)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            vld_q_reg <= vld_reg[rd_addr];
        end
        if (cmd.take_in)
        begin
            a_reg <= left_end;
            b_reg <= right_end;
            x_reg <= left_end;
        end
        if (cmd.rd_first)
        begin
            i_reg <= COEF_AW'(1);
        end
        if (cmd.ld_first)
        begin
            p_reg <= coef;
        end
        if (cmd.mul)
        begin
            prod_reg <= p_reg * x_reg;
        end
        if (cmd.acc)
        begin
            p_reg <= p_next;
            i_reg <= i_reg + COEF_AW'(1);
        end
        if (cmd.save_fa)
        begin
            fa_neg_reg  <= p_reg[DATA_W-1];
            fa_zero_reg <= (p_reg == '0);
            x_reg       <= b_reg;
        end
        if (cmd.set_mid)
        begin
            x_reg <= mid;
        end
        if (cmd.side)
        begin
            if (p_reg[DATA_W-1] == fa_neg_reg)
            begin
                a_reg <= x_reg;
            end
            else
            begin
                b_reg <= x_reg;
            end
        end
        if (cmd.out_load)
        begin
            root_reg   <= (cmd.out_status == ST_FOUND) ? x_reg : '0;
            status_reg <= cmd.out_status;
        end
    end

    assign root_value = root_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

// ----- hdl/pbrf_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbrf_ctrl
// Controller: sequences coefficient writes, Horner passes and bisection
// halvings, and owns the request handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_action,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire pbrf_pkg::pbrf_stat_t st,
    output pbrf_pkg::pbrf_cmd_t       cmd
);

    import pbrf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD0   = 8'b0000_0010,
        S_LD0   = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_EVEND = 8'b0010_0000,
        S_BIS   = 8'b0100_0000,
        S_POST  = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_C = 2'd2
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    res_status_t res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        cmd            = '0;
        cmd.out_status = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_action == ACT_WRITE)
                    begin
                        cmd.coef_wr = 1'b1;
                        res_next    = ST_WRITTEN;
                        state_next  = S_POST;
                    end
                    else
                    begin
                        cmd.take_in = 1'b1;
                        phase_next  = PH_A;
                        state_next  = S_RD0;
                    end
                end
            end
            S_RD0:
            begin
                cmd.rd_first = 1'b1;
                state_next   = S_LD0;
            end
            S_LD0:
            begin
                cmd.ld_first = 1'b1;
                state_next   = st.deg_zero ? S_EVEND : S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = st.last ? S_EVEND : S_MUL;
            end
            S_EVEND:
            begin
                case (phase_reg)
                    PH_A:
                    begin
                        cmd.save_fa = 1'b1;
                        phase_next  = PH_B;
                        state_next  = S_RD0;
                    end
                    PH_B:
                    begin
                        if (st.invalid)
                        begin
                            res_next   = ST_INVALID;
                            state_next = S_POST;
                        end
                        else
                        begin
                            cmd.set_mid = 1'b1;
                            phase_next  = PH_C;
                            state_next  = S_BIS;
                        end
                    end
                    PH_C:
                    begin
                        if (st.p_zero)
                        begin
                            res_next   = ST_FOUND;
                            state_next = S_POST;
                        end
                        else
                        begin
                            cmd.side   = 1'b1;
                            state_next = S_BIS;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_BIS:
            begin
                if (st.stop)
                begin
                    res_next   = ST_FOUND;
                    state_next = S_POST;
                end
                else
                begin
                    cmd.set_mid = 1'b1;
                    state_next  = S_RD0;
                end
            end
            S_POST:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_A;
            res_reg       <= ST_FOUND;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pbrf_checker.sv -----
// ----------------------------------------------------------------------------
// pbrf_checker
// Port-level checks of the root finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polynomial_bisection_root_finder_macros.svh"

module pbrf_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [pbrf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic [pbrf_pkg::STATUS_W-1:0]      m_axis_tuser
);

    import pbrf_pkg::*;

    `PBRF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result changed while stalled")

    `PBRF_ASSERT_SAME(a_zero_root, m_axis_tvalid && (m_axis_tuser != ST_FOUND),
        m_axis_tdata == '0, "nonzero root on a write or invalid result")

    `PBRF_ASSERT_NEXT(a_one_in_work, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "request taken while another is in work")

endmodule

bind polynomial_bisection_root_finder pbrf_checker u_pbrf_checker (.*);

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the polynomial bisection root finder. A queue of
// coefficient-write and solve requests feeds a bursty driver; a local Horner
// and bisection predictor computes each result at acceptance, and a monitor
// compares the returned root and status against it under random back-pressure.
// ----------------------------------------------------------------------------

module testbench;

    import pbrf_pkg::*;

    localparam int  CYCLE_LIMIT = 6000000;
    localparam int  HOLD_CYCLES = 600;
    localparam int  HOLD_AFTER  = 40;

    typedef logic [MAX_COEFFS-1:0][DATA_W-1:0] coef_bank_t;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  coef_index;
        logic [DATA_W-1:0] coef_value;
        logic [DATA_W-1:0] left_end;
        logic [DATA_W-1:0] right_end;
    } request_t;

    typedef struct packed {
        logic [DATA_W-1:0] root;
        res_status_t       status;
    } root_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    request_t     pending_requests[$];
    root_result_t expected_roots[$];

    coef_bank_t       model_bank = '0;
    coef_bank_t       plan_bank = '0;
    logic [DEG_W-1:0] degree_setting = '0;
    logic [TOL_W-1:0] tol_setting = TOL_RESET;

    int mismatches = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_left = 0;
    int rx_tick = 0;
    int rx_mode = 0;
    int results_taken = 0;
    bit held_once = 1'b0;

    polynomial_bisection_root_finder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] sat_q16(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < -longint'(32'sh7FFF_FFFF) - 1)
            return 32'sh8000_0000;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] horner_eval(
        input coef_bank_t bank, input logic [DEG_W-1:0] deg,
        input logic signed [DATA_W-1:0] x);
        logic signed [DATA_W-1:0] p;
        logic signed [DATA_W-1:0] ps;
        longint prod;
        int i;
        p = bank[0];
        for (i = 1; i <= int'(deg); i++)
        begin
            prod = (longint'(p) * longint'(x)) >>> 16;
            ps = sat_q16(prod);
            p = sat_q16(longint'(ps) + longint'($signed(bank[i])));
        end
        return p;
    endfunction

    function automatic logic signed [DATA_W-1:0] floor_mid(
        input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
        longint s;
        s = (longint'(a) + longint'(b)) >>> 1;
        return s[DATA_W-1:0];
    endfunction

    function automatic longint span_of(
        input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? -d : d;
    endfunction

    function automatic bit has_sign_change(
        input logic signed [DATA_W-1:0] fa, input logic signed [DATA_W-1:0] fb);
        return (fa != 0) && (fb != 0) && ((fa < 0) != (fb < 0));
    endfunction

    function automatic root_result_t find_root(
        input logic signed [DATA_W-1:0] left_x, input logic signed [DATA_W-1:0] right_x);
        root_result_t res;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] fa;
        logic signed [DATA_W-1:0] fc;
        bit hit;
        a = left_x;
        b = right_x;
        fa = horner_eval(model_bank, degree_setting, a);
        res.root = '0;
        res.status = ST_INVALID;
        if (!has_sign_change(fa, horner_eval(model_bank, degree_setting, b)))
            return res;
        hit = 1'b0;
        c = floor_mid(a, b);
        while (!hit && span_of(a, b) > longint'(tol_setting) && span_of(a, b) > 1)
        begin
            c = floor_mid(a, b);
            fc = horner_eval(model_bank, degree_setting, c);
            if (fc == 0)
                hit = 1'b1;
            else if ((fc < 0) == (fa < 0))
                a = c;
            else
                b = c;
        end
        res.root = c;
        res.status = ST_FOUND;
        return res;
    endfunction

    function automatic root_result_t resolve_request(input request_t r);
        root_result_t res;
        if (r.action == ACT_WRITE)
        begin
            model_bank[r.coef_index] = r.coef_value;
            res.root = '0;
            res.status = ST_WRITTEN;
            return res;
        end
        return find_root(r.left_end, r.right_end);
    endfunction

    function automatic logic [DATA_W-1:0] random_fixed();
        int span;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        span = 1 << (17 + $urandom_range(0, 4));
        return int'($urandom_range(0, span)) - span / 2;
    endfunction

    task automatic queue_write(input int idx, input logic [DATA_W-1:0] val);
        request_t r;
        r.action = ACT_WRITE;
        r.coef_index = idx[IDX_W-1:0];
        r.coef_value = val;
        r.left_end = $urandom;
        r.right_end = $urandom;
        plan_bank[idx[IDX_W-1:0]] = val;
        pending_requests.push_back(r);
    endtask

    task automatic queue_solve(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        request_t r;
        r.action = ACT_SOLVE;
        r.coef_index = IDX_W'($urandom);
        r.coef_value = $urandom;
        r.left_end = a;
        r.right_end = b;
        pending_requests.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_roots.size() != 0)
            @(negedge clk);
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_POLY_DEGREE)
            degree_setting = val[DEG_W-1:0];
        else
            tol_setting = val[TOL_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // driver: bursts with gaps, holds a request until taken
    always @(posedge clk)
    begin : driver
        request_t r;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = $urandom_range(1, 20);
            gap_left = 0;
        end
        else if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (s_axis_tvalid)
            begin
                expected_roots.push_back(resolve_request(pending_requests[0]));
                pending_requests.delete(0);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                r = pending_requests[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, r.right_end, r.left_end, r.coef_value, r.coef_index};
                s_axis_tuser  <= r.action;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: own stall pattern plus one long hold-off
    always @(posedge clk)
    begin : receiver
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                results_taken++;
            rx_tick++;
            if (rx_tick % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            if (!held_once && results_taken >= HOLD_AFTER && pending_requests.size() > 2)
            begin
                held_once = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= (rx_tick % 4 != 3);
                    2: m_axis_tready <= 1'($urandom_range(0, 1));
                    default:
                    begin
                        if ($urandom_range(0, 15) == 0)
                            stall_left = $urandom_range(5, 40);
                        m_axis_tready <= 1'b1;
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        root_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_roots.size() == 0)
            begin
                $display("%0t: result with nothing expected: root %0d status %0d", $time,
                         $signed(m_axis_tdata), m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_roots.pop_front();
                if (m_axis_tdata !== want.root)
                begin
                    $display("%0t: root mismatch: expected %0d actual %0d", $time,
                             $signed(want.root), $signed(m_axis_tdata));
                    mismatches++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d", $time,
                             want.status, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        int k;
        int n;
        int tries;
        int pick;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [CFG_W-1:0] tol_val;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: constant polynomial
        queue_solve(32'hFFFF_0000, 32'h0001_0000);
        queue_write(63, 32'h8000_0000);
        queue_write(0, 32'h7FFF_FFFF);
        queue_solve(32'h8000_0000, 32'h7FFF_FFFF);
        wait_drained();

        // line x - 3.0, exact search
        program_register(REG_POLY_DEGREE, 31'd1);
        program_register(REG_TOLERANCE, 31'd0);
        queue_write(0, 32'h0001_0000);
        queue_write(1, 32'hFFFD_0000);
        queue_solve(32'h0000_0000, 32'h000A_0000);
        queue_solve(32'h000A_0000, 32'h0000_0000);
        queue_solve(32'h0003_0000, 32'h0005_0000);
        queue_solve(32'h0004_0000, 32'h0005_0000);
        queue_solve(32'h8000_0000, 32'h7FFF_FFFF);
        queue_write(0, 32'h0002_0000);
        queue_write(1, 32'hFFFF_FFFF);
        queue_solve(32'h0000_0000, 32'h0000_0001);
        wait_drained();

        // widest tolerance: midpoint of the ends
        program_register(REG_TOLERANCE, 31'h7FFF_FFFF);
        queue_solve(32'hFFFB_0000, 32'h0007_0000);
        wait_drained();

        // full degree
        program_register(REG_POLY_DEGREE, 31'd63);
        queue_solve(32'hFFFF_0000, 32'h0002_0000);
        queue_solve(32'h8000_0000, 32'h7FFF_FFFF);
        wait_drained();
        program_register(REG_TOLERANCE, 31'd0);
        queue_solve(32'hFFFF_8000, 32'h0000_C000);
        queue_solve(32'h7FFF_FFFF, 32'h8000_0000);
        wait_drained();

        for (phase = 0; phase < 11; phase++)
        begin
            if (phase == 3)
                k = 63;
            else if (phase == 7)
                k = 0;
            else
                k = $urandom_range(1, 5);
            case ($urandom_range(0, 5))
                0: tol_val = 31'd0;
                1: tol_val = 31'd1;
                2: tol_val = TOL_RESET;
                3: tol_val = CFG_W'($urandom_range(0, 65535));
                4: tol_val = CFG_W'($urandom);
                default: tol_val = CFG_W'($urandom_range(2, 300));
            endcase
            program_register(REG_POLY_DEGREE, CFG_W'(k));
            program_register(REG_TOLERANCE, tol_val);

            for (int i = 0; i <= k; i++)
                queue_write(i, random_fixed());

            n = (k == 63) ? 6 : $urandom_range(10, 16);
            repeat (n)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    queue_write($urandom_range(0, 63), $urandom);
                else if (pick == 1)
                    queue_solve($urandom, $urandom);
                else
                begin
                    tries = 0;
                    do
                    begin
                        a = random_fixed();
                        b = random_fixed();
                        tries++;
                    end while (tries < 30 &&
                               !has_sign_change(horner_eval(plan_bank, DEG_W'(k), a),
                                                horner_eval(plan_bank, DEG_W'(k), b)));
                    queue_solve(a, b);
                end
                // hold the sender until the block has caught up
                if (phase == 5 && pending_requests.size() == 6)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
